/* hdl/bph_pkg.sv */
// bph_pkg: shared types, state and event codes and register defaults
// for the button press/hold/repeat block
// no dependencies
package bph_pkg;

  localparam int BUTTON_COUNT = 4;
  localparam int BTN_AW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int CNT_W = $clog2(BUTTON_COUNT + 1);
  localparam int RAW_W = 4;
  localparam int TICK_W = 16;
  localparam int CFG_AW = 2;
  localparam int ST_W = 3;
  localparam int EV_W = 3;
  localparam int IDX_W = 2;

  typedef logic [BTN_AW-1:0] btn_addr_t;
  typedef logic [CNT_W-1:0] btn_cnt_t;
  typedef logic [BUTTON_COUNT-1:0] btn_vec_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [ST_W-1:0] st_t;
  typedef logic [EV_W-1:0] ev_t;

  // button states
  localparam st_t ST_IDLE = 3'd0;
  localparam st_t ST_DEBOUNCE = 3'd1;
  localparam st_t ST_PRESSED = 3'd2;
  localparam st_t ST_HELD = 3'd3;
  localparam st_t ST_REPEAT = 3'd4;

  // event codes
  localparam ev_t EV_PRESSED = 3'd0;
  localparam ev_t EV_PRESS_RELEASED = 3'd1;
  localparam ev_t EV_HELD = 3'd2;
  localparam ev_t EV_HOLD_RELEASED = 3'd3;
  localparam ev_t EV_REPEAT = 3'd4;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_HOLD = 2'd1;
  localparam logic [CFG_AW-1:0] REG_REPEAT = 2'd2;
  localparam logic [CFG_AW-1:0] REG_ACTIVE_LOW = 2'd3;

  // register reset values
  localparam tick_t DEBOUNCE_RST = 16'd5;
  localparam tick_t HOLD_RST = 16'd100;
  localparam tick_t REPEAT_RST = 16'd20;
  localparam logic ACTIVE_LOW_RST = 1'b1;

  localparam tick_t TICK_MAX = '1;

  // per-button entry held in the state memory
  typedef struct packed {
    logic  prev_active;
    st_t   state;
    st_t   prior;
    tick_t elapsed;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
  localparam entry_t ENTRY_RST = '{prev_active: 1'b0, state: ST_IDLE, prior: ST_IDLE,
                                   elapsed: '0};

  // durations handed to the step logic
  typedef struct packed {
    tick_t debounce;
    tick_t hold;
    tick_t rpt;
  } dur_t;

  // outcome of one button step
  typedef struct packed {
    entry_t entry;
    logic   ev_valid;
    ev_t    ev_code;
  } step_res_t;

endpackage

/* hdl/bph_ram.sv */
// bph_ram: generic single write port, single read port ram with registered read
// no dependencies
module bph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/bph_step.sv */
// bph_step: next state, timer and event of one button for one poll tick
// depends on bph_pkg
module bph_step (
  input  bph_pkg::entry_t    cur,
  input  logic               act,
  input  bph_pkg::dur_t      dur,
  output bph_pkg::step_res_t res
);

  logic           rising;
  logic           falling;
  logic           starting;
  bph_pkg::tick_t el_t;
  bph_pkg::tick_t limit;
  logic           expired;

  always_comb begin
    rising = act & ~cur.prev_active;
    falling = ~act & cur.prev_active;
    starting = (cur.state != cur.prior);

    // timer start clears, otherwise count up and saturate
    if (starting) begin
      el_t = '0;
    end else if (cur.elapsed == bph_pkg::TICK_MAX) begin
      el_t = cur.elapsed;
    end else begin
      el_t = cur.elapsed + 1'b1;
    end

    case (cur.state) inside
      bph_pkg::ST_PRESSED, bph_pkg::ST_HELD: limit = dur.hold;
      bph_pkg::ST_REPEAT: limit = dur.rpt;
      default: limit = dur.debounce;
    endcase
    expired = (el_t >= limit);

    res.entry.prev_active = act;
    res.entry.state = cur.state;
    res.entry.prior = cur.state;
    res.entry.elapsed = cur.elapsed;
    res.ev_valid = 1'b0;
    res.ev_code = bph_pkg::EV_PRESSED;

    unique case (cur.state)
      bph_pkg::ST_IDLE: begin
        if (rising) begin
          res.entry.state = bph_pkg::ST_DEBOUNCE;
        end
      end
      bph_pkg::ST_DEBOUNCE: begin
        res.entry.elapsed = el_t;
        if (falling) begin
          res.entry.state = bph_pkg::ST_IDLE;
        end else if (expired) begin
          res.entry.state = bph_pkg::ST_PRESSED;
          res.ev_valid = 1'b1;
          res.ev_code = bph_pkg::EV_PRESSED;
        end
      end
      bph_pkg::ST_PRESSED: begin
        res.entry.elapsed = el_t;
        if (falling) begin
          res.entry.state = bph_pkg::ST_IDLE;
          res.ev_valid = 1'b1;
          res.ev_code = bph_pkg::EV_PRESS_RELEASED;
        end else if (expired) begin
          res.entry.state = bph_pkg::ST_HELD;
          res.ev_valid = 1'b1;
          res.ev_code = bph_pkg::EV_HELD;
        end
      end
      bph_pkg::ST_HELD: begin
        res.entry.elapsed = el_t;
        if (falling) begin
          res.entry.state = bph_pkg::ST_IDLE;
          res.ev_valid = 1'b1;
          res.ev_code = bph_pkg::EV_HOLD_RELEASED;
        end else if (expired) begin
          res.entry.state = bph_pkg::ST_REPEAT;
          res.ev_valid = 1'b1;
          res.ev_code = bph_pkg::EV_REPEAT;
        end
      end
      bph_pkg::ST_REPEAT: begin
        res.entry.elapsed = el_t;
        if (falling) begin
          res.entry.state = bph_pkg::ST_IDLE;
          res.ev_valid = 1'b1;
          res.ev_code = bph_pkg::EV_HOLD_RELEASED;
        end else if (expired) begin
          // repeat restarts its timer on the same step
          res.entry.elapsed = '0;
          res.ev_valid = 1'b1;
          res.ev_code = bph_pkg::EV_REPEAT;
        end
      end
      default: begin
        // unused state codes hold still
      end
    endcase
  end

endmodule

/* hdl/button_press_hold_repeat_fsm.sv */
// button_press_hold_repeat_fsm: top level, debounce / hold / auto-repeat per button
// depends on bph_pkg, bph_ram, bph_step
//
// channel  dir  handshake        payload
// s_axis   in   tvalid/tready    tdata[3:0] raw_levels
// m_axis   out  tvalid/tready    tdata[1:0] button_index, tdata[4:2] event_code,
//                                tlast last_event
// cfg      in   cfg_we           cfg_addr register index, cfg_wdata value
//
// a poll tick request issues the first state read when it is accepted, then
// takes each button in turn through the read-modify-write of the state ram,
// then closes the tick; the single state ram read port serializes the buttons
// reset clears the per-button valid bits at once, so there is no clearing pass
// events wait in a pending register until the next event or the end of the
// tick settles their last flag; a stalled output only holds the sequencer
// when the pending event has to move into a full output register
module button_press_hold_repeat_fsm (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [3:0] raw_levels
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,   // [1:0] button_index, [4:2] event_code
  output logic                       m_tlast,   // last_event
  input  logic                       cfg_we,
  input  logic [bph_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [15:0]                cfg_wdata
);

  // configuration registers
  bph_pkg::dur_t dur;
  logic          active_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      dur.debounce <= bph_pkg::DEBOUNCE_RST;
      dur.hold <= bph_pkg::HOLD_RST;
      dur.rpt <= bph_pkg::REPEAT_RST;
      active_low <= bph_pkg::ACTIVE_LOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bph_pkg::REG_DEBOUNCE: dur.debounce <= cfg_wdata;
        bph_pkg::REG_HOLD: dur.hold <= cfg_wdata;
        bph_pkg::REG_REPEAT: dur.rpt <= cfg_wdata;
        bph_pkg::REG_ACTIVE_LOW: active_low <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // sequencer state
  logic                   busy;
  logic                   rd_v;       // ram output holds entry of button mb
  bph_pkg::btn_addr_t     mb;         // button being modified
  bph_pkg::btn_cnt_t      nxt;        // next button to read
  logic [bph_pkg::RAW_W-1:0] levels;
  bph_pkg::btn_vec_t      vld;        // entry written since reset
  logic                   vld_q;      // valid bit of the entry being modified

  // pending event, last flag not yet known
  logic                   pend_v;
  bph_pkg::idx_t          pend_idx;
  bph_pkg::ev_t           pend_code;

  // output register
  logic                   out_v;
  bph_pkg::idx_t          out_idx;
  bph_pkg::ev_t           out_code;
  logic                   out_last;

  logic                   acc;
  logic                   out_free;
  logic                   stall;
  logic                   adv;
  logic                   issue;
  logic                   finish;
  bph_pkg::btn_addr_t     rd_addr;
  bph_pkg::btn_vec_t      lvl_ext;
  logic                   act;
  bph_pkg::entry_t        rdata_raw;
  bph_pkg::entry_t        cur;
  bph_pkg::step_res_t     res;

  assign acc = s_tvalid && s_tready;
  assign s_tready = !busy;
  assign out_free = !out_v || m_tready;

  // a second event of the tick must push the pending one out
  assign stall = res.ev_valid && pend_v && !out_free;
  assign adv = rd_v && !stall;
  assign issue = acc || (busy && (!rd_v || adv) && (nxt < bph_pkg::CNT_W'(bph_pkg::BUTTON_COUNT)));
  assign rd_addr = acc ? '0 : nxt[bph_pkg::BTN_AW-1:0];
  assign finish = busy && !rd_v && (nxt == bph_pkg::CNT_W'(bph_pkg::BUTTON_COUNT))
                  && (!pend_v || out_free);

  // buttons above the input width read level zero
  assign lvl_ext = bph_pkg::btn_vec_t'(levels);
  assign act = active_low ? ~lvl_ext[mb] : lvl_ext[mb];
  assign cur = vld_q ? rdata_raw : bph_pkg::ENTRY_RST;

  bph_ram #(
    .WIDTH(bph_pkg::ENTRY_W),
    .DEPTH(bph_pkg::BUTTON_COUNT)
  ) u_state_ram (
    .clk  (clk),
    .we   (adv),
    .waddr(mb),
    .wdata(res.entry),
    .re   (issue),
    .raddr(rd_addr),
    .rdata(rdata_raw)
  );

  bph_step u_step (
    .cur(cur),
    .act(act),
    .dur(dur),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rd_v <= 1'b0;
      nxt <= '0;
      vld <= '0;
      pend_v <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (acc) begin
        busy <= 1'b1;
        levels <= s_tdata[bph_pkg::RAW_W-1:0];
        nxt <= bph_pkg::btn_cnt_t'(1);
      end else if (issue) begin
        nxt <= nxt + 1'b1;
      end
      if (finish) begin
        busy <= 1'b0;
      end

      if (issue) begin
        rd_v <= 1'b1;
        mb <= rd_addr;
        vld_q <= vld[rd_addr];
      end else if (adv) begin
        rd_v <= 1'b0;
      end

      if (adv) begin
        vld[mb] <= 1'b1;
      end

      // pending and output registers
      if (adv && res.ev_valid) begin
        pend_v <= 1'b1;
        pend_idx <= bph_pkg::idx_t'(mb);
        pend_code <= res.ev_code;
      end else if (finish) begin
        pend_v <= 1'b0;
      end

      if ((adv && res.ev_valid && pend_v) || (finish && pend_v)) begin
        out_v <= 1'b1;
        out_idx <= pend_idx;
        out_code <= pend_code;
        out_last <= finish;
      end else if (m_tready) begin
        out_v <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata = {3'b000, out_code, out_idx};
  assign m_tlast = out_last;

endmodule
